>>> rtl/tfire_pkg.sv
// Shared types and constants for the triac phase-angle fire timer.
`timescale 1ns / 1ps

package tfire_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DELAY_W = 14;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CFG_W   = 16;

  // Action codes carried on the input tuser
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ZC    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LEVEL = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PULSE_TICKS = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAP_TICKS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_LEVEL   = 2'd2;

  localparam logic [TICK_W-1:0]  PULSE_TICKS_RST = 16'd1001;
  localparam logic [TICK_W-1:0]  GAP_TICKS_RST   = 16'd9001;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = 8'd5;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DELAY  = 3'd1,
    PH_PULSE1 = 3'd2,
    PH_GAP1   = 3'd3,
    PH_PULSE2 = 3'd4,
    PH_GAP2   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  pulse_ticks;
    logic [TICK_W-1:0]  gap_ticks;
    logic [LEVEL_W-1:0] min_level;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   gate;
  } res_t;

endpackage

>>> rtl/tfire_cfg.sv
// Configuration register bank: pulse length, gap length and minimum level.
`timescale 1ns / 1ps

module tfire_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfire_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tfire_pkg::CFG_W-1:0]     cfg_data,
  output tfire_pkg::cfg_t                 cfg
);

  tfire_pkg::cfg_t cfg_r;
  tfire_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tfire_pkg::REG_PULSE_TICKS: cfg_nxt.pulse_ticks = cfg_data;
        tfire_pkg::REG_GAP_TICKS:   cfg_nxt.gap_ticks   = cfg_data;
        tfire_pkg::REG_MIN_LEVEL:   cfg_nxt.min_level   = cfg_data[tfire_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks <= tfire_pkg::PULSE_TICKS_RST;
      cfg_r.gap_ticks   <= tfire_pkg::GAP_TICKS_RST;
      cfg_r.min_level   <= tfire_pkg::MIN_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/tfire_seq.sv
// Firing sequencer: delay, two gate pulses and their gaps, counted in ticks.
`timescale 1ns / 1ps

module tfire_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [tfire_pkg::ACT_W-1:0]     action,
  input  logic [tfire_pkg::LEVEL_W-1:0]   level,
  input  tfire_pkg::cfg_t                 cfg,
  output tfire_pkg::res_t                 res_nxt
);

  logic [tfire_pkg::DELAY_W-1:0] fire_delay_r, fire_delay_nxt;
  logic [tfire_pkg::TICK_W-1:0]  tick_count_r, tick_count_nxt;
  tfire_pkg::phase_t             phase_r, phase_nxt;
  logic                          gate_r, gate_nxt;
  logic [tfire_pkg::DELAY_W-1:0] new_delay;

  // ((255 - level) << 5) + 1, with 255 - level being the inverted level
  assign new_delay = {1'b0, ~level, 5'b00001};

  assign res_nxt.phase = phase_nxt;
  assign res_nxt.gate  = gate_nxt;

  always_comb begin
    fire_delay_nxt = fire_delay_r;
    tick_count_nxt = tick_count_r;
    phase_nxt      = phase_r;
    gate_nxt       = gate_r;
    if (step) begin
      unique case (action)
        tfire_pkg::ACT_TICK: begin
          if (phase_r != tfire_pkg::PH_IDLE) begin
            if (tick_count_r <= 16'd1) begin
              // end of phase: advance to the next one
              unique case (phase_r)
                tfire_pkg::PH_DELAY: begin
                  gate_nxt       = 1'b1;
                  tick_count_nxt = cfg.pulse_ticks;
                  phase_nxt      = tfire_pkg::PH_PULSE1;
                end
                tfire_pkg::PH_PULSE1: begin
                  gate_nxt       = 1'b0;
                  tick_count_nxt = cfg.gap_ticks;
                  phase_nxt      = tfire_pkg::PH_GAP1;
                end
                tfire_pkg::PH_GAP1: begin
                  gate_nxt       = 1'b1;
                  tick_count_nxt = cfg.pulse_ticks;
                  phase_nxt      = tfire_pkg::PH_PULSE2;
                end
                tfire_pkg::PH_PULSE2: begin
                  gate_nxt       = 1'b0;
                  tick_count_nxt = cfg.gap_ticks;
                  phase_nxt      = tfire_pkg::PH_GAP2;
                end
                default: begin
                  tick_count_nxt = '0;
                  phase_nxt      = tfire_pkg::PH_IDLE;
                end
              endcase
            end else begin
              tick_count_nxt = tick_count_r - 16'd1;
            end
          end
        end
        tfire_pkg::ACT_ZC: begin
          if (fire_delay_r == '0) begin
            gate_nxt = 1'b0;
          end else begin
            // restart; the gate holds its level until the delay runs out
            tick_count_nxt = {{(tfire_pkg::TICK_W - tfire_pkg::DELAY_W){1'b0}}, fire_delay_r};
            phase_nxt      = tfire_pkg::PH_DELAY;
          end
        end
        tfire_pkg::ACT_LEVEL: begin
          if (level < cfg.min_level) begin
            fire_delay_nxt = '0;
            tick_count_nxt = '0;
            phase_nxt      = tfire_pkg::PH_IDLE;
            gate_nxt       = 1'b0;
          end else begin
            fire_delay_nxt = new_delay;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_delay_r <= '0;
      tick_count_r <= '0;
      phase_r      <= tfire_pkg::PH_IDLE;
      gate_r       <= 1'b0;
    end else begin
      fire_delay_r <= fire_delay_nxt;
      tick_count_r <= tick_count_nxt;
      phase_r      <= phase_nxt;
      gate_r       <= gate_nxt;
    end
  end

  a_no_delay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire_delay_r == '0 |-> phase_r == tfire_pkg::PH_IDLE)
    else $error("sequence running without a stored delay");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tfire_pkg::PH_IDLE |-> tick_count_r == '0)
    else $error("tick count left over in idle");

  a_zc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && action == tfire_pkg::ACT_ZC && fire_delay_r != '0 |=>
      phase_r == tfire_pkg::PH_DELAY &&
      tick_count_r == {{(tfire_pkg::TICK_W - tfire_pkg::DELAY_W){1'b0}}, $past(fire_delay_r)})
    else $error("zero crossing did not reload the delay");

  a_tick_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    step && action == tfire_pkg::ACT_TICK && phase_r != tfire_pkg::PH_IDLE &&
      tick_count_r > 16'd1 |=>
      tick_count_r == $past(tick_count_r) - 16'd1 && $stable(phase_r))
    else $error("tick did not count down within the phase");

endmodule

>>> rtl/triac_phase_fire_timer_unit.sv
// Top level of the triac phase-angle fire timer: stream ports and beat registers.
`timescale 1ns / 1ps

// Usage
//   Input stream: one beat per event. in_tuser carries the action (0 tick of
//   one microsecond, 1 mains zero crossing, 2 set light level); in_tdata
//   carries the level, read only for a set-level beat.
//   Output stream: exactly one beat per input beat, in order, giving the gate
//   drive (bit 0) and sequence phase (bits 3:1) after that event.
//   Configuration: cfg_index selects pulse length (0), gap length (1) or
//   minimum level (2); written when cfg_valid and cfg_ready are high.
//   cfg_ready is always high. Write only while no beat is in flight.
// Timing
//   An accepted beat sits in the input register, then the sequencer update
//   lands in the output register, which drives out_tvalid and out_tdata.
//   Throughput is one beat per cycle while the receiver takes each output beat.
//   When the receiver stalls, the output beat holds and the input register
//   fills; in_tready then falls until the output beat is taken.
// Reset
//   rst_n is synchronous, active low: sequence idle, gate off, no delay
//   stored, both registers empty, configuration at its reset values.
module triac_phase_fire_timer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] level
  input  logic [1:0] in_tuser,   // [1:0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] triac_gate, [3:1] sequence_phase, [7:4] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  tfire_pkg::cfg_t cfg;
  tfire_pkg::res_t res_nxt;

  logic                           in_vld_r, in_vld_nxt;
  logic [tfire_pkg::ACT_W-1:0]    in_action_r;
  logic [tfire_pkg::LEVEL_W-1:0]  in_level_r;
  logic                           out_vld_r, out_vld_nxt;
  tfire_pkg::res_t                out_res_r;
  logic                           in_beat;
  logic                           adv;
  logic                           step;

  assign adv       = !out_vld_r || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;
  assign in_beat   = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_res_r.phase, out_res_r.gate};

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_beat) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload: hold unless a new beat lands
  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_action_r <= in_tuser;
      in_level_r  <= in_tdata;
    end
    if (step) begin
      out_res_r <= res_nxt;
    end
  end

  tfire_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfire_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .action  (in_action_r),
    .level   (in_level_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

endmodule
